@@ hdl/efts_pkg.sv @@
// Shared types and constants for the event-flag task scheduler.
// Depends on nothing; every other file of the block imports it.
package efts_pkg;

  localparam int DEF_MAX_TASKS = 16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLR   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COMMIT
  } efts_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  target_id;
    logic [15:0] event_bits;
    logic [7:0]  task_priority;
  } efts_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  assigned_id;
    logic        ready_found;
    logic [7:0]  ready_id;
    logic [15:0] ready_events;
  } efts_out_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        exec;
    logic        commit;
    logic        add_ok;
    logic [1:0]  op;
    logic [7:0]  target;
    logic [15:0] bits;
    logic [7:0]  prio;
    logic [7:0]  new_id;
  } efts_cmd_t;

  // Handed from cell i to cell i+1.
  typedef struct packed {
    logic        ins_seen;
    logic        hit_seen;
    logic        rdy_seen;
    logic [7:0]  sel_id;
    logic [15:0] sel_ev;
    logic        valid;
    logic [7:0]  ident;
    logic [7:0]  rank;
    logic [15:0] events;
  } efts_link_t;

endpackage

@@ hdl/efts_cell.sv @@
// One table slot of the scheduler: holds a task and resolves its part of
// each command against the prefix flags handed in by its neighbor. Uses efts_pkg.
module efts_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  efts_pkg::efts_cmd_t  cmd,
  input  efts_pkg::efts_link_t link_in,
  output efts_pkg::efts_link_t link_out
);
  import efts_pkg::*;

  logic        valid_r;
  logic [7:0]  ident_r;
  logic [7:0]  rank_r;
  logic [15:0] events_r;
  logic        ins_r;
  logic        hit_r;
  logic        rdy_r;
  logic        add_go;
  logic        upd_go;

  assign add_go = cmd.commit && cmd.op == OP_ADD && cmd.add_ok;
  assign upd_go = cmd.commit && (cmd.op == OP_SET || cmd.op == OP_CLR) &&
                  hit_r && !link_in.hit_seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (add_go) begin
      if (link_in.ins_seen) begin
        valid_r <= link_in.valid;
      end else if (ins_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ins_r <= !valid_r || (cmd.prio > rank_r);
      hit_r <= valid_r && (ident_r == cmd.target);
      rdy_r <= valid_r && (events_r != 16'd0);
    end
    if (add_go) begin
      if (link_in.ins_seen) begin
        ident_r  <= link_in.ident;
        rank_r   <= link_in.rank;
        events_r <= link_in.events;
      end else if (ins_r) begin
        ident_r  <= cmd.new_id;
        rank_r   <= cmd.prio;
        events_r <= 16'd0;
      end
    end else if (upd_go) begin
      if (cmd.op == OP_SET) begin
        events_r <= events_r | cmd.bits;
      end else begin
        events_r <= events_r & ~cmd.bits;
      end
    end
  end

  always_comb begin
    link_out.ins_seen = link_in.ins_seen | ins_r;
    link_out.hit_seen = link_in.hit_seen | hit_r;
    link_out.rdy_seen = link_in.rdy_seen | rdy_r;
    if (link_in.rdy_seen) begin
      link_out.sel_id = link_in.sel_id;
      link_out.sel_ev = link_in.sel_ev;
    end else if (rdy_r) begin
      link_out.sel_id = ident_r;
      link_out.sel_ev = events_r;
    end else begin
      link_out.sel_id = 8'd0;
      link_out.sel_ev = 16'd0;
    end
    link_out.valid  = valid_r;
    link_out.ident  = ident_r;
    link_out.rank   = rank_r;
    link_out.events = events_r;
  end

endmodule

@@ hdl/event_flag_task_scheduler.sv @@
// Top level of the event-flag task scheduler: controller, output register and
// the row of efts_cell slots. Uses efts_pkg and efts_cell.
//
// The task table is a row of MAX_TASKS cells kept in service order, cell 0
// served first. In the exec state of each beat every cell compares
// its own task against the request (insert point, identifier match, pending
// events) and registers the flags; at commit the flags ripple down the row
// as running prefixes, which picks the insert point, the first matching task
// and the first ready task, and every cell updates at once (an add shifts the
// tail of the row one cell onward). A new beat is taken in the cycle the
// previous one commits, and a commit waits until the output slot is free.
// The result sits in an output register, so the next request is accepted
// while a result still waits. The ripple through the row sets the critical
// path, which grows with MAX_TASKS. A write of first_task_id is always taken;
// it reloads the identifier counter only while no task has been added since
// reset.
module event_flag_task_scheduler #(
  parameter int MAX_TASKS = efts_pkg::DEF_MAX_TASKS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  efts_pkg::efts_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output efts_pkg::efts_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import efts_pkg::*;

  efts_state_t state_r, state_nxt;
  efts_in_t    req_r;
  logic [7:0]  next_id_r;
  logic        out_valid_r;
  efts_out_t   out_data_r;
  efts_out_t   res;
  efts_cmd_t   cmd;
  efts_link_t  link [MAX_TASKS+1];
  logic [MAX_TASKS-1:0] vld;
  logic        full;
  logic        empty;
  logic        fire;
  logic        take;
  logic        do_exec;
  logic        do_commit;

  // Output slot is free when empty or being drained this cycle.
  assign fire = !out_valid_r || !out_stall;
  assign full  = vld[MAX_TASKS-1];
  assign empty = !vld[0];

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and strobes; accept in idle or in the committing cycle.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    do_exec   = 1'b0;
    do_commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        do_exec   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (fire) begin
          do_commit = 1'b1;
          in_stall  = 1'b0;
          state_nxt = in_valid ? S_EXEC : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign take = in_valid && !in_stall;

  // Hold the request through the exec and commit states.
  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    cmd.exec   = do_exec;
    cmd.commit = do_commit;
    cmd.add_ok = !full;
    cmd.op     = req_r.op;
    cmd.target = req_r.target_id;
    cmd.bits   = req_r.event_bits;
    cmd.prio   = req_r.task_priority;
    cmd.new_id = next_id_r;
  end

  assign link[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      efts_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .link_in  (link[gi]),
        .link_out (link[gi+1])
      );
      assign vld[gi] = link[gi+1].valid;
    end
  endgenerate

  // Identifier counter: advance on a successful add, reload from the
  // register port while the table is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= 8'd0;
    end else if (do_commit && req_r.op == OP_ADD && !full) begin
      next_id_r <= next_id_r + 8'd1;
    end else if (cfg_valid && cfg_ready && empty) begin
      next_id_r <= cfg_data;
    end
  end

  // Build the result from the end of the row.
  always_comb begin
    res = '0;
    unique case (req_r.op)
      OP_ADD: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.assigned_id = next_id_r;
        end
      end
      OP_SET, OP_CLR: begin
        res.status = link[MAX_TASKS].hit_seen ? ST_OK : ST_NOTFOUND;
      end
      OP_QUERY: begin
        res.ready_found  = link[MAX_TASKS].rdy_seen;
        res.ready_id     = link[MAX_TASKS].sel_id;
        res.ready_events = link[MAX_TASKS].sel_ev;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      out_data_r <= res;
    end
  end

  // Occupied cells always form an unbroken run from cell 0.
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld >> 1) & ~vld) == '0)
    else $error("task table has a gap");

  // A successful add grows the table by exactly one task.
  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_commit && req_r.op == OP_ADD && !full) |=>
      $countones(vld) == $past($countones(vld)) + 1)
    else $error("add did not grow the table by one");

  // An add on a full table reports full and leaves the counter alone.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (do_commit && req_r.op == OP_ADD && full) |=>
      (out_data_r.status == ST_FULL) && $stable(next_id_r))
    else $error("full add mishandled");

  // Set, clear and query never change the population.
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (do_commit && req_r.op != OP_ADD) |=> $stable(vld))
    else $error("non-add command changed the table population");

endmodule
